// ----- hw/rtl/dsnw_pkg.sv -----
// ----------------------------------------------------------------------------
// dsnw_pkg - shared types and constants for the 8.3 short name matcher
// Slot counts, character codes, register indexes, phase codes and the
// pattern summary that the pattern block hands to the name core.
// ----------------------------------------------------------------------------
package dsnw_pkg;

    localparam int SLOTS      = 11;
    localparam int BASE_SLOTS = 8;
    localparam int EXT_SLOTS  = SLOTS - BASE_SLOTS;
    localparam int POS_W      = $clog2(SLOTS + 1);

    localparam logic [POS_W-1:0] POS_BASE_END = POS_W'(BASE_SLOTS);
    localparam logic [POS_W-1:0] POS_EXT_END  = POS_W'(SLOTS);

    localparam logic [7:0] CHAR_DOT     = 8'h2e;
    localparam logic [7:0] CHAR_STAR    = 8'h2a;
    localparam logic [7:0] CHAR_QMARK   = 8'h3f;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_EXT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_ALL    = 2'd2;

    // dot name tracker codes
    localparam logic [1:0] DOT_NONE  = 2'd0;
    localparam logic [1:0] DOT_ONE   = 2'd1;
    localparam logic [1:0] DOT_TWO   = 2'd2;
    localparam logic [1:0] DOT_OTHER = 2'd3;

    typedef enum logic [1:0] {
        PH_BASE = 2'd0,
        PH_SKIP = 2'd1,
        PH_EXT  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef logic [SLOTS-1:0] slot_vec_t;

    typedef struct packed {
        logic [SLOTS-1:0][7:0] bytes;     // pattern byte per slot
        slot_vec_t             free;      // slot matches any character
        slot_vec_t             ok_space;  // slot accepts a blank
        slot_vec_t             ok_qmark;  // slot accepts a '?'
        logic                  dot1_ok;   // fixed form of "." matches
        logic                  dot2_ok;   // fixed form of ".." matches
        logic                  match_all;
    } pat_info_t;

    // true if any slot in [lo, hi) rejects the pad character
    function automatic logic range_bad(input logic [POS_W-1:0] lo,
                                       input logic [POS_W-1:0] hi,
                                       input slot_vec_t        okv);
        logic bad;
        bad = 1'b0;
        for (int p = 0; p < SLOTS; p++)
        begin
            if ((POS_W'(p) >= lo) && (POS_W'(p) < hi) && !okv[p])
            begin
                bad = 1'b1;
            end
        end
        return bad;
    endfunction

endpackage

// ----- hw/rtl/dsnw_pattern.sv -----
// ----------------------------------------------------------------------------
// dsnw_pattern - pattern registers and per-slot match summary
// Holds the three configuration registers and derives, per slot, whether
// the slot is free, accepts a blank or a '?', plus the dot name verdicts.
// ----------------------------------------------------------------------------
module dsnw_pattern
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dsnw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dsnw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output dsnw_pkg::pat_info_t               pat
);

    logic [8*dsnw_pkg::BASE_SLOTS-1:0] pattern_base_reg;
    logic [8*dsnw_pkg::EXT_SLOTS-1:0]  pattern_ext_reg;
    logic                              match_all_reg;

    logic [dsnw_pkg::SLOTS-1:0][7:0]   bytes;
    dsnw_pkg::slot_vec_t               zero_prefix;
    dsnw_pkg::slot_vec_t               free;
    dsnw_pkg::slot_vec_t               ok_space;
    logic                              dot0_ok;
    logic                              dot1s_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_base_reg <= '0;
            pattern_ext_reg  <= '0;
            match_all_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dsnw_pkg::CFG_PATTERN_BASE:
                    pattern_base_reg <= cfg_wdata[8*dsnw_pkg::BASE_SLOTS-1:0];
                dsnw_pkg::CFG_PATTERN_EXT:
                    pattern_ext_reg <= cfg_wdata[8*dsnw_pkg::EXT_SLOTS-1:0];
                dsnw_pkg::CFG_MATCH_ALL:
                    match_all_reg <= cfg_wdata[0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        bytes = {pattern_ext_reg, pattern_base_reg};
        // a zero byte ends the pattern: it and every later slot match anything
        zero_prefix[0] = (bytes[0] == dsnw_pkg::CHAR_NUL);
        for (int p = 1; p < dsnw_pkg::SLOTS; p++)
        begin
            zero_prefix[p] = zero_prefix[p-1] | (bytes[p] == dsnw_pkg::CHAR_NUL);
        end
        for (int p = 0; p < dsnw_pkg::SLOTS; p++)
        begin
            free[p]     = zero_prefix[p] | (bytes[p] == dsnw_pkg::CHAR_QMARK);
            ok_space[p] = free[p] | (bytes[p] == dsnw_pkg::CHAR_SPACE);
        end
        dot0_ok  = free[0] | (bytes[0] == dsnw_pkg::CHAR_DOT);
        dot1s_ok = free[1] | (bytes[1] == dsnw_pkg::CHAR_DOT);

        pat.bytes     = bytes;
        pat.free      = free;
        pat.ok_space  = ok_space;
        pat.ok_qmark  = free;
        pat.dot1_ok   = dot0_ok & ok_space[1] & (&ok_space[dsnw_pkg::SLOTS-1:2]);
        pat.dot2_ok   = dot0_ok & dot1s_ok & (&ok_space[dsnw_pkg::SLOTS-1:2]);
        pat.match_all = match_all_reg;
    end

endmodule

// ----- hw/rtl/dsnw_core.sv -----
// ----------------------------------------------------------------------------
// dsnw_core - name expansion and slot compare
// Registers each input beat, then in one pass expands it into 8.3 slots,
// updates phase/position/fill state and produces the match bit on the
// last character of a name.
// ----------------------------------------------------------------------------
module dsnw_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  dsnw_pkg::pat_info_t  pat,
    input  logic [1:0]           out_level,
    input  logic                 out_pop,
    output logic                 res_valid,
    output logic                 res_matched
);

    logic                           in_valid_reg;
    logic [7:0]                     in_char_reg;
    logic                           in_last_reg;

    dsnw_pkg::phase_t               phase_reg, phase_next;
    logic [dsnw_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                           wild_reg, wild_next;
    logic                           miss_reg, miss_next;
    logic [1:0]                     dot_reg, dot_next;

    dsnw_pkg::phase_t               ph1;
    logic [dsnw_pkg::POS_W-1:0]     pos1;
    logic                           w1;
    logic                           m1;
    logic                           m2;
    logic [7:0]                     u;
    logic [7:0]                     pb;
    logic                           pb_free;
    logic                           char_ok;
    logic                           is_dot;
    logic                           is_star;
    dsnw_pkg::slot_vec_t            fill_old;
    dsnw_pkg::slot_vec_t            fill_new;
    logic                           ok;
    logic                           accept;

    // a last beat in flight will need a result slot; two slots in total,
    // and a result leaving this cycle frees one
    assign s_tready = ({1'b0, out_level} + {2'b0, in_valid_reg & in_last_reg})
                    < ({2'b0, out_pop} + 3'd2);
    assign accept   = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dsnw_pkg::PH_BASE;
            pos_reg   <= '0;
            wild_reg  <= 1'b0;
            miss_reg  <= 1'b0;
            dot_reg   <= dsnw_pkg::DOT_NONE;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            wild_reg  <= wild_next;
            miss_reg  <= miss_next;
            dot_reg   <= dot_next;
        end
    end

    always_comb
    begin
        is_dot  = (in_char_reg == dsnw_pkg::CHAR_DOT);
        is_star = (in_char_reg == dsnw_pkg::CHAR_STAR);

        if (in_char_reg inside {[dsnw_pkg::CHAR_LOWER_A:dsnw_pkg::CHAR_LOWER_Z]})
        begin
            u = in_char_reg - dsnw_pkg::CASE_OFFSET;
        end
        else
        begin
            u = in_char_reg;
        end
        if (is_star)
        begin
            u = dsnw_pkg::CHAR_QMARK;
        end

        if (pos_reg < dsnw_pkg::POS_EXT_END)
        begin
            pb      = pat.bytes[pos_reg];
            pb_free = pat.free[pos_reg];
        end
        else
        begin
            pb      = dsnw_pkg::CHAR_NUL;
            pb_free = 1'b1;
        end
        char_ok  = pb_free | (pb == u);
        fill_old = wild_reg ? pat.ok_qmark : pat.ok_space;

        // dot name tracker
        case (dot_reg)
            dsnw_pkg::DOT_NONE: dot_next = is_dot ? dsnw_pkg::DOT_ONE : dsnw_pkg::DOT_OTHER;
            dsnw_pkg::DOT_ONE:  dot_next = is_dot ? dsnw_pkg::DOT_TWO : dsnw_pkg::DOT_OTHER;
            default:            dot_next = dsnw_pkg::DOT_OTHER;
        endcase

        // character step
        ph1  = phase_reg;
        pos1 = pos_reg;
        w1   = wild_reg;
        m1   = miss_reg;
        case (phase_reg)
            dsnw_pkg::PH_BASE:
            begin
                if (is_dot)
                begin
                    m1   = miss_reg | dsnw_pkg::range_bad(pos_reg, dsnw_pkg::POS_BASE_END,
                                                          fill_old);
                    pos1 = dsnw_pkg::POS_BASE_END;
                    w1   = 1'b0;
                    ph1  = dsnw_pkg::PH_EXT;
                end
                else
                begin
                    if (is_star)
                    begin
                        w1 = 1'b1;
                    end
                    m1   = miss_reg | !char_ok;
                    pos1 = pos_reg + 1'b1;
                    if (pos1 >= dsnw_pkg::POS_BASE_END)
                    begin
                        ph1 = dsnw_pkg::PH_SKIP;
                    end
                end
            end
            dsnw_pkg::PH_SKIP:
            begin
                if (is_dot)
                begin
                    pos1 = dsnw_pkg::POS_BASE_END;
                    w1   = 1'b0;
                    ph1  = dsnw_pkg::PH_EXT;
                end
            end
            dsnw_pkg::PH_EXT:
            begin
                if (is_dot)
                begin
                    m1   = miss_reg | dsnw_pkg::range_bad(pos_reg, dsnw_pkg::POS_EXT_END,
                                                          fill_old);
                    pos1 = dsnw_pkg::POS_EXT_END;
                    ph1  = dsnw_pkg::PH_DONE;
                end
                else
                begin
                    if (is_star)
                    begin
                        w1 = 1'b1;
                    end
                    if (pos_reg < dsnw_pkg::POS_EXT_END)
                    begin
                        m1   = miss_reg | !char_ok;
                        pos1 = pos_reg + 1'b1;
                    end
                    if (pos1 >= dsnw_pkg::POS_EXT_END)
                    begin
                        ph1 = dsnw_pkg::PH_DONE;
                    end
                end
            end
            default:
                ;
        endcase

        // end-of-name padding from the updated state
        fill_new = w1 ? pat.ok_qmark : pat.ok_space;
        case (ph1)
            dsnw_pkg::PH_BASE:
                m2 = m1
                   | dsnw_pkg::range_bad(pos1, dsnw_pkg::POS_BASE_END, fill_new)
                   | dsnw_pkg::range_bad(dsnw_pkg::POS_BASE_END, dsnw_pkg::POS_EXT_END,
                                         pat.ok_space);
            dsnw_pkg::PH_SKIP:
                m2 = m1
                   | dsnw_pkg::range_bad(dsnw_pkg::POS_BASE_END, dsnw_pkg::POS_EXT_END,
                                         pat.ok_space);
            dsnw_pkg::PH_EXT:
                m2 = m1 | dsnw_pkg::range_bad(pos1, dsnw_pkg::POS_EXT_END, fill_new);
            default:
                m2 = m1;
        endcase

        if (pat.match_all)
        begin
            ok = 1'b1;
        end
        else if (dot_next == dsnw_pkg::DOT_ONE)
        begin
            ok = pat.dot1_ok;
        end
        else if (dot_next == dsnw_pkg::DOT_TWO)
        begin
            ok = pat.dot2_ok;
        end
        else
        begin
            ok = !m2;
        end

        phase_next = phase_reg;
        pos_next   = pos_reg;
        wild_next  = wild_reg;
        miss_next  = miss_reg;
        if (in_valid_reg)
        begin
            if (in_last_reg)
            begin
                phase_next = dsnw_pkg::PH_BASE;
                pos_next   = '0;
                wild_next  = 1'b0;
                miss_next  = 1'b0;
                dot_next   = dsnw_pkg::DOT_NONE;
            end
            else
            begin
                phase_next = ph1;
                pos_next   = pos1;
                wild_next  = w1;
                miss_next  = m1;
            end
        end
        else
        begin
            dot_next = dot_reg;
        end

        res_valid   = in_valid_reg & in_last_reg;
        res_matched = ok;
    end

endmodule

// ----- hw/rtl/dsnw_out_buf.sv -----
// ----------------------------------------------------------------------------
// dsnw_out_buf - two-entry result buffer
// Output register plus skid entry so results can land while the
// receiver stalls; reports its fill level upstream.
// ----------------------------------------------------------------------------
module dsnw_out_buf
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       push_data,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic       m_data,
    output logic [1:0] level
);

    logic out_valid_reg, out_valid_next;
    logic out_data_reg, out_data_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_data_reg, skid_data_next;
    logic pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_comb
    begin
        pop             = out_valid_reg & m_tready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = push;
            out_data_next  = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_data   = out_data_reg;
    assign level    = {1'b0, out_valid_reg} + {1'b0, skid_valid_reg};

endmodule

// ----- hw/rtl/dos_short_name_wildcard_match.sv -----
// ----------------------------------------------------------------------------
// dos_short_name_wildcard_match - 8.3 file name wildcard matcher
// Streams a file name one character per beat and reports whether its
// 8.3 expansion matches the configured 11-slot pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one name character per beat in s_tdata, s_tlast on the
//   final character. Master channel: one beat per name, m_tdata[0] = match.
//   Configuration: cfg_we with cfg_index 0 (base pattern, 8 bytes), 1 (ext
//   pattern, 3 bytes), 2 (match-all flag); write only while idle.
//   Throughput: one character per cycle while s_tready is high; each beat is
//   registered, then expanded and compared against all slots combinationally.
//   Result path: after the last character is accepted, the match bit goes
//   through the input register and then the result buffer to m_tvalid.
//   Stall: a two-entry result buffer keeps s_tready high while a result
//   waits; input stalls only once both entries are full or about to be.
//   Reset: pattern and match-all clear (an all-zero pattern matches every
//   name), name state returns to the start of a name, buffer empties.
// ----------------------------------------------------------------------------
module dos_short_name_wildcard_match
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] name_char
    input  logic                              s_tlast,   // is_last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [0] matched, [7:1] zero
    input  logic                              cfg_we,
    input  logic [dsnw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dsnw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    dsnw_pkg::pat_info_t pat;
    logic [1:0]          out_level;
    logic                out_pop;
    logic                res_valid;
    logic                res_matched;
    logic                out_matched;

    assign out_pop = m_tvalid & m_tready;

    dsnw_pattern u_pattern
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pat       (pat)
    );

    dsnw_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .pat         (pat),
        .out_level   (out_level),
        .out_pop     (out_pop),
        .res_valid   (res_valid),
        .res_matched (res_matched)
    );

    dsnw_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_matched),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (out_matched),
        .level     (out_level)
    );

    assign m_tdata = {7'b0, out_matched};

endmodule
